@@ rtl/lfla_pkg.sv @@
// lfla_pkg: request and response beat types and status codes of the block allocator
package lfla_pkg;

  localparam int unsigned ID_FIELD_W    = 11;
  localparam int unsigned GRANT_FIELD_W = 10;
  localparam int unsigned COUNT_FIELD_W = 11;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_INVALID   = 2'd2,
    ST_DOUBLE    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [ID_FIELD_W-1:0]   block_id;
  } req_t;

  typedef struct packed {
    logic [GRANT_FIELD_W-1:0] granted_block;
    status_t                  status;
    logic [COUNT_FIELD_W-1:0] free_blocks;
  } rsp_t;

endpackage

@@ rtl/lifo_free_list_block_allocator.sv @@
// lifo_free_list_block_allocator: free-id stack and allocated marks in synchronous memories
//
// Each request is accepted in the idle state, which issues the reads of the stack
// memory (at the top of the stack) and the mark memory (at the requested id); the
// execute state then checks, updates both memories and loads the response register.
// A new request is taken once the block is back in its idle state; a response that
// is not taken holds the execute state until the response register frees up. There
// is no clearing pass after reset: a low-water count of the stack depth tells which
// stack entries have never been written and which ids have never been handed out,
// so the block accepts requests as soon as reset is released.
module lifo_free_list_block_allocator
  import lfla_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int unsigned IDW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CW  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned EW  = (CW > ID_FIELD_W) ? CW : ID_FIELD_W;
  localparam logic [CW-1:0] NUM_C  = CW'(NUM_BLOCKS);
  localparam logic [CW-1:0] LAST_C = CW'(NUM_BLOCKS - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic [CW-1:0]  lwm;
  logic [CW-1:0]  lwm_next;

  cmd_t           cmd_q;
  logic [IDW-1:0] id_q;
  logic           in_range_q;

  logic [IDW-1:0] stack_mem [NUM_BLOCKS];
  logic           mark_mem  [NUM_BLOCKS];
  logic [IDW-1:0] stack_rd;
  logic           mark_rd;

  logic           req_fire;
  logic           rsp_load;
  logic [EW-1:0]  id_wide;
  logic [IDW-1:0] req_idx;
  logic           req_in_range;
  logic [CW-1:0]  top;
  logic [IDW-1:0] rd_addr;
  logic [IDW-1:0] blk;
  logic           marked;
  logic           stack_we;
  logic           mark_we;
  logic [IDW-1:0] mark_addr;
  logic           mark_wd;
  rsp_t           rsp_next;

  assign req_ready    = (state == S_IDLE);
  assign req_fire     = req_valid && req_ready;
  assign rsp_load     = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  assign id_wide      = EW'(req.block_id);
  assign req_idx      = id_wide[IDW-1:0];
  assign req_in_range = id_wide < EW'(NUM_BLOCKS);
  assign top          = count - 1'b1;
  assign rd_addr      = (count == '0) ? '0 : top[IDW-1:0];

  always_comb begin
    blk        = (top < lwm) ? IDW'(LAST_C - top) : stack_rd;
    // ids at or above NUM_BLOCKS - lwm were never handed out, so their mark is clear
    marked     = mark_rd && (CW'(id_q) < (NUM_C - lwm));
    state_next = state;
    count_next = count;
    lwm_next   = lwm;
    stack_we   = 1'b0;
    mark_we    = 1'b0;
    mark_addr  = id_q;
    mark_wd    = 1'b0;
    rsp_next   = rsp;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (rsp_load) begin
          state_next             = S_IDLE;
          rsp_next.granted_block = '0;
          rsp_next.status        = ST_OK;
          if (cmd_q == CMD_ALLOC) begin
            if (count == '0) begin
              rsp_next.status = ST_NONE_FREE;
            end else begin
              count_next             = top;
              lwm_next               = (top < lwm) ? top : lwm;
              mark_we                = 1'b1;
              mark_addr              = blk;
              mark_wd                = 1'b1;
              rsp_next.granted_block = GRANT_FIELD_W'(blk);
            end
          end else begin
            if (!in_range_q) begin
              rsp_next.status = ST_INVALID;
            end else if (!marked) begin
              rsp_next.status = ST_DOUBLE;
            end else begin
              mark_we = 1'b1;
              if (count < NUM_C) begin
                stack_we   = 1'b1;
                count_next = count + 1'b1;
              end
            end
          end
          rsp_next.free_blocks = COUNT_FIELD_W'(count_next);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= NUM_C;
      lwm       <= NUM_C;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      lwm   <= lwm_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd_q      <= req.cmd;
      id_q       <= req_idx;
      in_range_q <= req_in_range;
    end
    rsp <= rsp_next;
  end

  // free-id stack
  always_ff @(posedge clk) begin
    if (req_fire) begin
      stack_rd <= stack_mem[rd_addr];
    end
    if (stack_we) begin
      stack_mem[count[IDW-1:0]] <= id_q;
    end
  end

  // allocated marks
  always_ff @(posedge clk) begin
    if (req_fire) begin
      mark_rd <= mark_mem[req_idx];
    end
    if (mark_we) begin
      mark_mem[mark_addr] <= mark_wd;
    end
  end

`ifndef SYNTHESIS
  a_count_bounds: assert property (@(posedge clk) disable iff (rst)
    (count <= NUM_C) && (lwm <= count))
    else $error("stack count or low-water mark out of bounds");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state == S_EXEC) && !req_ready)
    else $error("accepted beat not followed by execute cycle");

  a_alloc_pop: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && (cmd_q == CMD_ALLOC) && (count != '0)) |=> (count == $past(count) - 1'b1))
    else $error("grant without pop");

  a_free_push: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && (cmd_q == CMD_FREE) && in_range_q && marked)
      |=> (count == $past(count) + 1'b1))
    else $error("free of marked block without push");
`endif

endmodule
